/* rtl/core/tcd_pkg.sv */
package tcd_pkg;

    // Fixed field widths
    localparam int SLOT_W = 10;
    localparam int CFG_W  = 11;
    localparam int CNT_W  = 11;
    localparam int POS_W  = 10;
    localparam int CFG_INDEX_W = 2;

    // Parameter defaults
    localparam int NUM_SLOTS_DEF    = 1024;
    localparam int VOLTAGE_BITS_DEF = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = '0;
    localparam logic [CFG_W-1:0] HIT_CAPACITY_RST = CFG_W'(1024);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_SLOTS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIT_CAPACITY = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_RESEED = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Slot table write enables
    typedef struct packed {
        logic thr_we;
        logic flag_we;
    } wr_ctl_t;

endpackage

/* rtl/core/tcd_slot_table.sv */
module tcd_slot_table #(
    parameter int NUM_SLOTS    = tcd_pkg::NUM_SLOTS_DEF,
    parameter int VOLTAGE_BITS = tcd_pkg::VOLTAGE_BITS_DEF,
    parameter int ADDR_W       = $clog2(NUM_SLOTS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    input  logic [ADDR_W-1:0]       cur_addr,
    input  tcd_pkg::wr_ctl_t        wr_ctl,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [VOLTAGE_BITS-1:0] wr_thr,
    input  logic                    wr_flag,
    output logic [VOLTAGE_BITS-1:0] cur_thr,
    output logic                    cur_flag
);
    import tcd_pkg::*;

    logic [VOLTAGE_BITS-1:0] thr_mem [NUM_SLOTS];
    logic                    flag_mem [NUM_SLOTS];

    logic [VOLTAGE_BITS-1:0] rd_thr_reg;
    logic                    rd_flag_reg;

    // last write, missed by the read issued at the same edge
    wr_ctl_t                 byp_ctl_reg;
    logic [ADDR_W-1:0]       byp_addr_reg;
    logic [VOLTAGE_BITS-1:0] byp_thr_reg;
    logic                    byp_flag_reg;

    always_ff @(posedge clk)
    begin
        if (wr_ctl.thr_we)
        begin
            thr_mem[wr_addr] <= wr_thr;
        end
        if (wr_ctl.flag_we)
        begin
            flag_mem[wr_addr] <= wr_flag;
        end
        if (rd_en)
        begin
            rd_thr_reg  <= thr_mem[rd_addr];
            rd_flag_reg <= flag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_ctl_reg <= '0;
        end
        else
        begin
            byp_ctl_reg <= wr_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_addr_reg <= wr_addr;
        byp_thr_reg  <= wr_thr;
        byp_flag_reg <= wr_flag;
    end

    always_comb
    begin
        cur_thr  = rd_thr_reg;
        cur_flag = rd_flag_reg;
        if (byp_ctl_reg.thr_we && (byp_addr_reg == cur_addr))
        begin
            cur_thr = byp_thr_reg;
        end
        if (byp_ctl_reg.flag_we && (byp_addr_reg == cur_addr))
        begin
            cur_flag = byp_flag_reg;
        end
    end

endmodule

/* rtl/core/tcd_detect.sv */
module tcd_detect #(
    parameter int NUM_SLOTS    = tcd_pkg::NUM_SLOTS_DEF,
    parameter int VOLTAGE_BITS = tcd_pkg::VOLTAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  tcd_pkg::op_t                  item_op,
    input  logic [tcd_pkg::SLOT_W-1:0]    item_slot,
    input  logic signed [VOLTAGE_BITS-1:0] item_voltage,
    input  logic                          item_scan_start,
    input  logic                          item_initial_flag,
    input  logic signed [VOLTAGE_BITS-1:0] cur_thr,
    input  logic                          cur_flag,
    input  logic [tcd_pkg::CFG_W-1:0]     active_slots,
    input  logic [tcd_pkg::CFG_W-1:0]     hit_capacity,
    output tcd_pkg::wr_ctl_t              wr_ctl,
    output logic                          wr_flag,
    output logic                          res_hit,
    output logic [tcd_pkg::POS_W-1:0]     res_position,
    output logic                          res_overflow,
    output logic                          res_slot_error,
    output logic [tcd_pkg::CNT_W-1:0]     res_count
);
    import tcd_pkg::*;

    localparam int NS_W = $clog2(NUM_SLOTS + 1);
    localparam int CW   = (CFG_W > NS_W) ? CFG_W : NS_W;
    localparam logic [CW-1:0] NUM_SLOTS_CW = CW'(NUM_SLOTS);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_base;
    logic [CW-1:0]    eff_active;
    logic [CW-1:0]    eff_capacity;
    logic             above;
    logic             crossing;
    logic             room;

    always_comb
    begin
        eff_active   = (CW'(active_slots) > NUM_SLOTS_CW) ? NUM_SLOTS_CW : CW'(active_slots);
        eff_capacity = (CW'(hit_capacity) > NUM_SLOTS_CW) ? NUM_SLOTS_CW : CW'(hit_capacity);
        cnt_base     = item_scan_start ? '0 : cnt_reg;
        above        = item_voltage > cur_thr;
        room         = CW'(cnt_base) < eff_capacity;
        crossing     = 1'b0;

        wr_ctl         = '0;
        wr_flag        = 1'b0;
        res_slot_error = CW'(item_slot) >= eff_active;

        if (item_valid && !res_slot_error)
        begin
            unique case (item_op)
                OP_LOAD:
                begin
                    wr_ctl.thr_we  = 1'b1;
                    wr_ctl.flag_we = 1'b1;
                    wr_flag        = item_initial_flag;
                end
                OP_SAMPLE:
                begin
                    wr_ctl.flag_we = 1'b1;
                    wr_flag        = above;
                    crossing       = above && !cur_flag;
                end
                OP_RESEED:
                begin
                    wr_ctl.flag_we = 1'b1;
                    wr_flag        = above;
                end
                default:
                begin
                    wr_ctl = '0;
                end
            endcase
        end

        res_hit      = crossing && room;
        res_overflow = crossing && !room;
        res_position = res_hit ? cnt_base[POS_W-1:0] : '0;
        res_count    = res_hit ? cnt_base + CNT_W'(1) : cnt_base;
        cnt_next     = item_valid ? res_count : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/core/threshold_crossing_detector_core.sv */
// Rising threshold crossing detector. One command word is taken on each
// clock edge where start is high (busy stays low, so a word can come every
// cycle); its result word, after the stage-1 and result registers, is shown
// for exactly one cycle, marked by done. The receiver cannot stall: done is
// a strobe, not a handshake, so results must be captured when shown. Every
// accepted word gives exactly one result word, in order. The result path is
// the registered read of the per-slot threshold/flag memories plus the
// result register; a back-to-back word for the same slot sees the previous
// write through a one-entry bypass. Thresholds and flags are not cleared at
// reset: load a slot before sampling or reseeding it. Configuration writes
// (cfg_ready is always high) must only be done while no result is pending.
module threshold_crossing_detector_core #(
    parameter int NUM_SLOTS    = tcd_pkg::NUM_SLOTS_DEF,
    parameter int VOLTAGE_BITS = tcd_pkg::VOLTAGE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command words
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         operation,
    input  logic [tcd_pkg::SLOT_W-1:0]         slot,
    input  logic signed [VOLTAGE_BITS-1:0]     voltage,
    input  logic signed [VOLTAGE_BITS-1:0]     new_threshold,
    input  logic                               initial_flag,
    input  logic                               scan_start,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcd_pkg::CFG_W-1:0]          cfg_data,
    // result words
    output logic                               done,
    output logic                               hit,
    output logic [tcd_pkg::SLOT_W-1:0]         hit_slot,
    output logic [tcd_pkg::POS_W-1:0]          hit_position,
    output logic                               overflow,
    output logic                               slot_error,
    output logic [tcd_pkg::CNT_W-1:0]          hits_in_scan
);
    import tcd_pkg::*;

    localparam int ADDR_W = $clog2(NUM_SLOTS);
    localparam int IW     = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;

    logic accept;

    // config registers
    logic [CFG_W-1:0] active_slots_reg;
    logic [CFG_W-1:0] hit_capacity_reg;

    // stage 1: command word, memory read in flight
    logic                           s1_valid_reg;
    op_t                            s1_op_reg;
    logic [SLOT_W-1:0]              s1_slot_reg;
    logic signed [VOLTAGE_BITS-1:0] s1_volt_reg;
    logic [VOLTAGE_BITS-1:0]        s1_nth_reg;
    logic                           s1_iflag_reg;
    logic                           s1_start_reg;

    // result register
    logic              done_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] hit_slot_reg;
    logic [POS_W-1:0]  hit_position_reg;
    logic              overflow_reg;
    logic              slot_error_reg;
    logic [CNT_W-1:0]  hits_in_scan_reg;

    logic [IW-1:0]           rd_slot_wide;
    logic [IW-1:0]           s1_slot_wide;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       s1_addr;
    logic [VOLTAGE_BITS-1:0] cur_thr;
    logic                    cur_flag;
    wr_ctl_t                 wr_ctl;
    logic                    wr_flag;

    logic             res_hit;
    logic [POS_W-1:0] res_position;
    logic             res_overflow;
    logic             res_slot_error;
    logic [CNT_W-1:0] res_count;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign rd_slot_wide = IW'(slot);
    assign s1_slot_wide = IW'(s1_slot_reg);
    assign rd_addr      = rd_slot_wide[ADDR_W-1:0];
    assign s1_addr      = s1_slot_wide[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slots_reg <= ACTIVE_SLOTS_RST;
            hit_capacity_reg <= HIT_CAPACITY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ACTIVE_SLOTS)
            begin
                active_slots_reg <= cfg_data;
            end
            else if (cfg_index == CFG_HIT_CAPACITY)
            begin
                hit_capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= op_t'(operation);
            s1_slot_reg  <= slot;
            s1_volt_reg  <= voltage;
            s1_nth_reg   <= new_threshold;
            s1_iflag_reg <= initial_flag;
            s1_start_reg <= scan_start;
        end
        if (s1_valid_reg)
        begin
            hit_reg          <= res_hit;
            hit_slot_reg     <= s1_slot_reg;
            hit_position_reg <= res_position;
            overflow_reg     <= res_overflow;
            slot_error_reg   <= res_slot_error;
            hits_in_scan_reg <= res_count;
        end
    end

    tcd_slot_table #(
        .NUM_SLOTS    (NUM_SLOTS),
        .VOLTAGE_BITS (VOLTAGE_BITS),
        .ADDR_W       (ADDR_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .cur_addr (s1_addr),
        .wr_ctl   (wr_ctl),
        .wr_addr  (s1_addr),
        .wr_thr   (s1_nth_reg),
        .wr_flag  (wr_flag),
        .cur_thr  (cur_thr),
        .cur_flag (cur_flag)
    );

    tcd_detect #(
        .NUM_SLOTS    (NUM_SLOTS),
        .VOLTAGE_BITS (VOLTAGE_BITS)
    ) u_detect (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (s1_valid_reg),
        .item_op           (s1_op_reg),
        .item_slot         (s1_slot_reg),
        .item_voltage      (s1_volt_reg),
        .item_scan_start   (s1_start_reg),
        .item_initial_flag (s1_iflag_reg),
        .cur_thr           (cur_thr),
        .cur_flag          (cur_flag),
        .active_slots      (active_slots_reg),
        .hit_capacity      (hit_capacity_reg),
        .wr_ctl            (wr_ctl),
        .wr_flag           (wr_flag),
        .res_hit           (res_hit),
        .res_position      (res_position),
        .res_overflow      (res_overflow),
        .res_slot_error    (res_slot_error),
        .res_count         (res_count)
    );

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign hit_slot     = hit_slot_reg;
    assign hit_position = hit_position_reg;
    assign overflow     = overflow_reg;
    assign slot_error   = slot_error_reg;
    assign hits_in_scan = hits_in_scan_reg;

endmodule
